/* src/tof_pkg.sv */
// Shared types and constants of the telnet option filter.
// Holds the item structs, the job descriptor and the reply sequence tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tof_pkg;

  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_TX      = 2'd1;
  localparam logic [1:0] OP_CONNECT = 2'd2;

  localparam logic [1:0] CFG_TELNET_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_NEWLINE_CONVERSION = 2'd1;
  localparam logic [1:0] CFG_LISTENING_MODE     = 2'd2;

  localparam logic [7:0] BYTE_IAC      = 8'hFF;
  localparam logic [7:0] BYTE_DONT     = 8'hFE;
  localparam logic [7:0] BYTE_DO       = 8'hFD;
  localparam logic [7:0] BYTE_WONT     = 8'hFC;
  localparam logic [7:0] BYTE_WILL     = 8'hFB;
  localparam logic [7:0] BYTE_SB       = 8'hFA;
  localparam logic [7:0] BYTE_SE       = 8'hF0;
  localparam logic [7:0] OPT_ECHO      = 8'h01;
  localparam logic [7:0] OPT_SGA       = 8'h03;
  localparam logic [7:0] OPT_LINEMODE  = 8'h22;
  localparam logic [7:0] CHAR_NATIVE_EOL = 8'h9B;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] LINEMODE_MODE = 8'h01;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;

  localparam logic DEST_TERMINAL = 1'b0;
  localparam logic DEST_NETWORK  = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       destination;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    JOB_ONE,
    JOB_TX_FF,
    JOB_TX_CRLF,
    JOB_REPLY,
    JOB_LINEMODE,
    JOB_CONNECT
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       dest;
    logic [7:0] data;
    logic [7:0] verb;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef logic [3:0] seq_idx_t;

  function automatic seq_idx_t job_len(input job_kind_t kind);
    seq_idx_t len;
    case (kind)
      JOB_ONE:      len = 4'd1;
      JOB_TX_FF:    len = 4'd2;
      JOB_TX_CRLF:  len = 4'd2;
      JOB_REPLY:    len = 4'd3;
      JOB_LINEMODE: len = 4'd10;
      JOB_CONNECT:  len = 4'd9;
      default:      len = 4'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] job_byte(input job_t job, input seq_idx_t idx);
    logic [7:0] b;
    b = BYTE_ZERO;
    case (job.kind)
      JOB_ONE:     b = job.data;
      JOB_TX_FF:   b = BYTE_IAC;
      JOB_TX_CRLF: b = (idx == 4'd0) ? CHAR_CR : CHAR_LF;
      JOB_REPLY: begin
        case (idx)
          4'd0:    b = BYTE_IAC;
          4'd1:    b = job.verb;
          default: b = job.data;
        endcase
      end
      JOB_LINEMODE: begin
        case (idx)
          4'd0:    b = BYTE_IAC;
          4'd1:    b = BYTE_SB;
          4'd2:    b = OPT_LINEMODE;
          4'd3:    b = LINEMODE_MODE;
          4'd4:    b = BYTE_ZERO;
          4'd5:    b = BYTE_IAC;
          4'd6:    b = BYTE_SE;
          4'd7:    b = BYTE_IAC;
          4'd8:    b = BYTE_DONT;
          default: b = OPT_LINEMODE;
        endcase
      end
      JOB_CONNECT: begin
        case (idx)
          4'd0:    b = BYTE_IAC;
          4'd1:    b = BYTE_WILL;
          4'd2:    b = OPT_ECHO;
          4'd3:    b = BYTE_IAC;
          4'd4:    b = BYTE_DO;
          4'd5:    b = OPT_SGA;
          4'd6:    b = BYTE_IAC;
          4'd7:    b = BYTE_DO;
          default: b = OPT_LINEMODE;
        endcase
      end
      default: b = job.data;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/telnet_option_filter.sv */
// Telnet option filter, top level: front parser, job queue and back sequencer.
// Path: an accepted item's job is written into the job queue, and its first result is loaded
// from the queue head into the output register.
// Throughput: while out_ready is high, one item and one result per cycle for items with a
// single result; longer replies hold the back sequencer; input stalls once two jobs wait.
// Reset: synchronous active-low rst_n clears parser state, registers and queue.
// Depends on tof_pkg, tof_front, tof_queue and tof_back.
`timescale 1ns / 1ps
`default_nettype none

module telnet_option_filter import tof_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_payload,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_payload
);

  logic          accept;
  logic          push;
  logic          pop;
  job_t          new_job;
  job_t          head;
  queue_status_t q_status;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  tof_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_payload),
    .push      (push),
    .job       (new_job)
  );

  tof_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (new_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  tof_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .head_valid  (!q_status.empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

  // A byte for the terminal is always the only result of its item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.destination || out_payload.last))
    else $error("terminal byte without last");

  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !q_status.full)
    else $error("job queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("job queue underflow");

endmodule

`default_nettype wire

/* src/tof_front.sv */
// Front end of the telnet option filter: configuration registers, IAC parser
// and newline tracking. Classifies each item into a job descriptor. Uses tof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tof_front import tof_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic       cfg_data,
  input  wire logic       accept,
  input  wire in_item_t   item,
  output logic            push,
  output job_t            job
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_CMD, PH_DO, PH_DONT, PH_WILL, PH_WONT
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   te_r, nl_r, lm_r;
  logic   sub_r, sub_nxt;
  logic   await_echo_r, await_echo_nxt;
  logic   await_sga_r, await_sga_nxt;
  logic   in_cr_r, in_cr_nxt;
  logic   out_cr_r, out_cr_nxt;
  logic   native_r, native_nxt;

  logic       conv;
  logic       deliver;
  logic [7:0] c;

  assign c    = item.data_byte;
  assign conv = te_r && nl_r && !native_r;

  always_comb begin
    phase_nxt      = phase_r;
    sub_nxt        = sub_r;
    await_echo_nxt = await_echo_r;
    await_sga_nxt  = await_sga_r;
    in_cr_nxt      = in_cr_r;
    out_cr_nxt     = out_cr_r;
    native_nxt     = native_r;
    deliver        = 1'b0;
    push           = 1'b0;
    job.kind       = JOB_ONE;
    job.dest       = DEST_NETWORK;
    job.data       = c;
    job.verb       = BYTE_WONT;
    if (accept) begin
      case (item.opcode)
        OP_RX: begin
          phase_nxt = PH_IDLE;
          if (!te_r) begin
            push     = 1'b1;
            job.dest = DEST_TERMINAL;
          end else begin
            case (phase_r)
              PH_CMD: begin
                if (c == BYTE_SE) begin
                  sub_nxt = 1'b0;
                end else if (c == BYTE_SB) begin
                  sub_nxt = 1'b1;
                end else if (c == BYTE_WILL) begin
                  phase_nxt = PH_WILL;
                end else if (c == BYTE_WONT) begin
                  phase_nxt = PH_WONT;
                end else if (c == BYTE_DO) begin
                  phase_nxt = PH_DO;
                end else if (c == BYTE_DONT) begin
                  phase_nxt = PH_DONT;
                end else if (c == BYTE_IAC) begin
                  deliver = 1'b1;
                end
              end
              PH_DO: begin
                job.kind = JOB_REPLY;
                if (c == OPT_ECHO) begin
                  if (await_echo_r) begin
                    await_echo_nxt = 1'b0;
                  end else begin
                    push     = 1'b1;
                    job.verb = lm_r ? BYTE_DONT : BYTE_WONT;
                  end
                end else if (c == OPT_SGA) begin
                  push     = 1'b1;
                  job.verb = BYTE_WILL;
                end else begin
                  push     = 1'b1;
                  job.verb = BYTE_WONT;
                end
              end
              PH_DONT: begin
                push     = 1'b1;
                job.kind = JOB_REPLY;
                job.verb = (c == OPT_SGA) ? BYTE_WILL : BYTE_WONT;
              end
              PH_WILL: begin
                job.kind = JOB_REPLY;
                job.verb = BYTE_DO;
                if (c == OPT_ECHO) begin
                  push = 1'b1;
                end else if (c == OPT_SGA) begin
                  if (await_sga_r) begin
                    await_sga_nxt = 1'b0;
                  end else begin
                    push = 1'b1;
                  end
                end else begin
                  push     = 1'b1;
                  job.verb = BYTE_DONT;
                  if (c == OPT_LINEMODE && lm_r) begin
                    job.kind = JOB_LINEMODE;
                  end
                end
              end
              PH_WONT: begin
                job.kind = JOB_REPLY;
                job.verb = BYTE_DONT;
                push     = lm_r && (c == OPT_ECHO);
              end
              default: begin
                if (c == BYTE_IAC) begin
                  phase_nxt = PH_CMD;
                end else begin
                  deliver = 1'b1;
                end
              end
            endcase
            if (deliver && !sub_r) begin
              push     = 1'b1;
              job.kind = JOB_ONE;
              job.dest = DEST_TERMINAL;
              if (lm_r && conv) begin
                if (c == CHAR_NATIVE_EOL) begin
                  native_nxt = 1'b1;
                end else if (c == CHAR_CR) begin
                  in_cr_nxt = 1'b1;
                end else if (in_cr_r) begin
                  in_cr_nxt = 1'b0;
                  push      = (c != CHAR_LF);
                end
              end
            end
          end
        end
        OP_TX: begin
          push = 1'b1;
          if (conv) begin
            if (c == CHAR_CR) begin
              out_cr_nxt = 1'b1;
            end else if (out_cr_r) begin
              out_cr_nxt = 1'b0;
              push       = (c != CHAR_LF);
            end
          end
          if (c == BYTE_IAC) begin
            job.kind = JOB_TX_FF;
          end else if (c == CHAR_CR && conv) begin
            job.kind = JOB_TX_CRLF;
          end
        end
        OP_CONNECT: begin
          phase_nxt      = PH_IDLE;
          sub_nxt        = 1'b0;
          in_cr_nxt      = 1'b0;
          out_cr_nxt     = 1'b0;
          native_nxt     = 1'b0;
          await_echo_nxt = lm_r && te_r;
          await_sga_nxt  = lm_r && te_r;
          push           = lm_r && te_r;
          job.kind       = JOB_CONNECT;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      te_r         <= 1'b0;
      nl_r         <= 1'b0;
      lm_r         <= 1'b0;
      sub_r        <= 1'b0;
      await_echo_r <= 1'b0;
      await_sga_r  <= 1'b0;
      in_cr_r      <= 1'b0;
      out_cr_r     <= 1'b0;
      native_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      sub_r        <= sub_nxt;
      await_echo_r <= await_echo_nxt;
      await_sga_r  <= await_sga_nxt;
      in_cr_r      <= in_cr_nxt;
      out_cr_r     <= out_cr_nxt;
      native_r     <= native_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TELNET_ENABLE:      te_r <= cfg_data;
          CFG_NEWLINE_CONVERSION: nl_r <= cfg_data;
          CFG_LISTENING_MODE:     lm_r <= cfg_data;
          default:                te_r <= te_r;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* src/tof_queue.sv */
// Two-entry job queue between the front and back ends of the option filter.
// Push and pop may happen in the same cycle. Uses tof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tof_queue import tof_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire job_t    push_job,
  input  wire logic    pop,
  output job_t         head,
  output queue_status_t status
);

  job_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign head         = entry_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/tof_back.sv */
// Back end of the option filter: expands the job at the queue head into
// result items, one per cycle while out_ready does not stall it, into the output register. Uses tof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tof_back import tof_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire job_t      head,
  input  wire logic      head_valid,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_payload
);

  seq_idx_t  idx_r;
  logic      out_valid_r;
  out_item_t out_payload_r;
  logic      load;
  logic      is_last;

  assign load        = head_valid && (!out_valid_r || out_ready);
  assign is_last     = (idx_r == job_len(head.kind) - 4'd1);
  assign pop         = load && is_last;
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_payload_r.destination <= head.dest;
      out_payload_r.out_byte    <= job_byte(head, idx_r);
      out_payload_r.last        <= is_last;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? '0 : idx_r + 4'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire
